// File: sv/hprd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat peak rate detector package
// Shared widths, constants, configuration and job types.
// ----------------------------------------------------------------------------
package hprd_pkg;

    localparam int RAW_W   = 16;              // raw timestamp and sample width
    localparam int TIME_W  = 17;              // corrected time width
    localparam int IVL_W   = TIME_W + 2;      // signed interval width
    localparam int RATE_W  = 8;
    localparam int QUO_W   = 16;              // quotient of the per-minute division
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 16;

    localparam int TIME_WRAP     = 60000;
    localparam int SAMPLE_STEP   = 8;
    localparam int STEP_CHECKS   = 4;
    localparam int MS_PER_MINUTE = 60000;

    localparam logic [ADDR_W-1:0] CFG_PEAK_THRESHOLD = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_MIN_INTERVAL   = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_MIN_RATE       = 2'd2;
    localparam logic [ADDR_W-1:0] CFG_MAX_RATE       = 2'd3;

    localparam logic [RAW_W-1:0]  RST_PEAK_THRESHOLD = 16'd700;
    localparam logic [RAW_W-1:0]  RST_MIN_INTERVAL   = 16'd300;
    localparam logic [RATE_W-1:0] RST_MIN_RATE       = 8'd30;
    localparam logic [RATE_W-1:0] RST_MAX_RATE       = 8'd200;

    typedef struct packed {
        logic [RAW_W-1:0]  peak_threshold;
        logic [RAW_W-1:0]  min_interval_ms;
        logic [RATE_W-1:0] min_rate;
        logic [RATE_W-1:0] max_rate;
    } t_cfg;

    // One classified word handed from the front end to the rate unit.
    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              peak;
        logic              update;
        logic [TIME_W-1:0] divisor;
    } t_job;

endpackage

// File: sv/heartbeat_peak_rate_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat peak rate detector
// Corrects sample timestamps, detects pulse peaks and tracks heart rate.
// ----------------------------------------------------------------------------
// Path: each input word is registered in the front end, passes the job queue
// and then the rate unit; a peak that computes a rate also runs the 16-step
// serial divider. The rate unit takes no new word until the last is registered.
// Reset: synchronous, active low; clears state and loads default registers.
module heartbeat_peak_rate_detector_top import hprd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [RAW_W-1:0]  i_time_ms,
    input  logic [RAW_W-1:0]  i_sample,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [TIME_W-1:0] o_corrected_time,
    output logic              o_peak_found,
    output logic [RATE_W-1:0] o_rate_bpm,
    output logic              o_rate_updated
);

    t_cfg r_cfg;
    logic push;
    logic push_ready;
    t_job push_job;
    logic q_valid;
    t_job q_job;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_threshold  <= RST_PEAK_THRESHOLD;
            r_cfg.min_interval_ms <= RST_MIN_INTERVAL;
            r_cfg.min_rate        <= RST_MIN_RATE;
            r_cfg.max_rate        <= RST_MAX_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PEAK_THRESHOLD: r_cfg.peak_threshold  <= i_cfg_wdata;
                CFG_MIN_INTERVAL:   r_cfg.min_interval_ms <= i_cfg_wdata;
                CFG_MIN_RATE:       r_cfg.min_rate        <= i_cfg_wdata[RATE_W-1:0];
                CFG_MAX_RATE:       r_cfg.max_rate        <= i_cfg_wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hprd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_time_ms    (i_time_ms),
        .i_sample     (i_sample),
        .o_push       (push),
        .o_job        (push_job),
        .i_push_ready (push_ready)
    );

    hprd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_job        (q_job),
        .i_pop        (pop)
    );

    hprd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (q_valid),
        .i_job            (q_job),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_corrected_time (o_corrected_time),
        .o_peak_found     (o_peak_found),
        .o_rate_bpm       (o_rate_bpm),
        .o_rate_updated   (o_rate_updated)
    );

endmodule

// File: sv/hprd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Corrects timestamps, measures the interval since the last peak and
// classifies each word as peak, first peak or plain sample.
// ----------------------------------------------------------------------------
module hprd_front import hprd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [RAW_W-1:0]  i_time_ms,
    input  logic [RAW_W-1:0]  i_sample,
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_push_ready
);

    logic [TIME_W-1:0]       r_prev_time;
    logic [TIME_W-1:0]       r_last_peak;
    logic                    r_have_peak;
    logic                    r_s1_valid;
    logic [TIME_W-1:0]       r_s1_now;
    logic [RAW_W-1:0]        r_s1_sample;

    logic [TIME_W-1:0]       fixed_time;
    logic [TIME_W:0]         probe;
    logic                    accept;
    logic                    pushed;
    logic                    wrap;
    logic signed [IVL_W-1:0] interval;
    logic                    beyond_min;
    logic                    is_peak;

    // A repeated or stepped-back timestamp lands one step past the previous
    // corrected time; the smallest matching step back wins.
    always_comb begin
        fixed_time = TIME_W'(i_time_ms);
        probe      = '0;
        for (int k = STEP_CHECKS - 1; k >= 0; k--) begin
            probe = (TIME_W + 1)'(i_time_ms) + (TIME_W + 1)'(k * SAMPLE_STEP);
            if (probe == {1'b0, r_prev_time}) begin
                fixed_time = TIME_W'(i_time_ms) + TIME_W'((k + 1) * SAMPLE_STEP);
            end
        end
    end

    assign pushed     = r_s1_valid && i_push_ready;
    assign o_in_ready = !r_s1_valid || i_push_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Wrap when the interval falls below minus the minimum interval.
    assign wrap = ({1'b0, r_s1_now} + {2'b00, i_cfg.min_interval_ms}) < {1'b0, r_last_peak};

    always_comb begin
        interval = $signed({2'b00, r_s1_now}) - $signed({2'b00, r_last_peak});
        if (wrap) begin
            interval = interval + $signed(IVL_W'(TIME_WRAP));
        end
    end

    assign beyond_min = interval > $signed({3'b000, i_cfg.min_interval_ms});
    assign is_peak    = (r_s1_sample > i_cfg.peak_threshold) && (!r_have_peak || beyond_min);

    assign o_push         = r_s1_valid;
    assign o_job.now      = r_s1_now;
    assign o_job.peak     = is_peak;
    assign o_job.update   = is_peak && r_have_peak;
    assign o_job.divisor  = interval[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_prev_time <= '0;
            r_last_peak <= '0;
            r_have_peak <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid  <= 1'b1;
                r_prev_time <= fixed_time;
            end else if (pushed) begin
                r_s1_valid <= 1'b0;
            end
            if (pushed && is_peak) begin
                r_last_peak <= r_s1_now;
                r_have_peak <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_now    <= fixed_time;
            r_s1_sample <= i_sample;
        end
    end

endmodule

// File: sv/hprd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry shifting queue between the front end and the rate unit.
// ----------------------------------------------------------------------------
module hprd_queue import hprd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_push_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    logic       r_vld [2];
    t_job       r_ent [2];
    logic       n_vld [2];
    t_job       n_ent [2];
    logic       do_pop;
    logic       do_push;

    assign o_push_ready = !r_vld[1];
    assign o_valid      = r_vld[0];
    assign o_job        = r_ent[0];
    assign do_pop       = i_pop && r_vld[0];
    assign do_push      = i_push && !r_vld[1];

    // The head always sits in entry zero; a pop shifts the tail forward.
    always_comb begin
        n_vld[0] = r_vld[0];
        n_vld[1] = r_vld[1];
        n_ent[0] = r_ent[0];
        n_ent[1] = r_ent[1];
        if (do_pop) begin
            n_vld[0] = r_vld[1];
            n_ent[0] = r_ent[1];
            n_vld[1] = 1'b0;
        end
        if (do_push) begin
            if (!n_vld[0]) begin
                n_vld[0] = 1'b1;
                n_ent[0] = i_job;
            end else begin
                n_vld[1] = 1'b1;
                n_ent[1] = i_job;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[0] <= n_vld[0];
            r_vld[1] <= n_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent[0] <= n_ent[0];
        r_ent[1] <= n_ent[1];
    end

endmodule

// File: sv/hprd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate unit
// For a rate word, divides the minute by the peak interval one quotient bit
// per cycle, applies the rate limits and drives the registered result word.
// ----------------------------------------------------------------------------
module hprd_back import hprd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [TIME_W-1:0] o_corrected_time,
    output logic              o_peak_found,
    output logic [RATE_W-1:0] o_rate_bpm,
    output logic              o_rate_updated
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic [TIME_W-1:0]  r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic [RATE_W-1:0]  r_rate;
    logic               r_out_valid;
    logic [TIME_W-1:0]  r_out_time;
    logic               r_out_peak;
    logic               r_out_upd;

    logic [TIME_W:0]    trial;
    logic [TIME_W:0]    diff;
    logic               fits;
    logic               out_free;
    logic               finish;
    logic [RATE_W-1:0]  n_rate;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign diff  = trial - {1'b0, r_job.divisor};
    assign fits  = trial >= {1'b0, r_job.divisor};

    assign out_free = !r_out_valid || i_out_ready;
    assign finish   = (r_state == ST_DONE) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;

    // Too slow reads as zero; too fast is dropped and the old rate stays.
    always_comb begin
        n_rate = r_rate;
        if (r_job.update) begin
            if (r_quo < {{(QUO_W - RATE_W){1'b0}}, i_cfg.min_rate}) begin
                n_rate = '0;
            end else if (r_quo <= {{(QUO_W - RATE_W){1'b0}}, i_cfg.max_rate}) begin
                n_rate = r_quo[RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= i_job.update ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (finish) begin
                r_rate      <= n_rate;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_rem <= '0;
            r_quo <= QUO_W'(MS_PER_MINUTE);
            r_cnt <= CNT_W'(QUO_W - 1);
        end else if (r_state == ST_DIV) begin
            r_rem <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (finish) begin
            r_out_time <= r_job.now;
            r_out_peak <= r_job.peak;
            r_out_upd  <= r_job.update;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_corrected_time = r_out_time;
    assign o_peak_found     = r_out_peak;
    assign o_rate_bpm       = r_rate;
    assign o_rate_updated   = r_out_upd;

endmodule
